// ===== design/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared constants, the lead byte table and the command type for the
// UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned LenWidth = 3;
   localparam int unsigned ErrWidth = 3;

   localparam logic [20:0] Replacement = 21'h00FFFD;

   // continuation byte ranges
   localparam logic [7:0] ContLo   = 8'h80;
   localparam logic [7:0] ContHi   = 8'hBF;
   localparam logic [7:0] E0SecLo  = 8'hA0;
   localparam logic [7:0] EdSecHi  = 8'h9F;
   localparam logic [7:0] F0SecLo  = 8'h90;
   localparam logic [7:0] F4SecHi  = 8'h8F;
   localparam logic [7:0] ContMask = 8'h3F;
   localparam logic [7:0] Mask2    = 8'h1F;
   localparam logic [7:0] Mask3    = 8'h0F;
   localparam logic [7:0] Mask4    = 8'h07;

   // lead bytes with a narrowed second-byte range
   localparam logic [7:0] LeadE0 = 8'hE0;
   localparam logic [7:0] LeadEd = 8'hED;
   localparam logic [7:0] LeadF0 = 8'hF0;
   localparam logic [7:0] LeadF4 = 8'hF4;

   // lead class bounds
   localparam logic [7:0] AsciiEnd = 8'h80;
   localparam logic [7:0] TwoBeg   = 8'hC2;
   localparam logic [7:0] ThreeBeg = 8'hE0;
   localparam logic [7:0] FourBeg  = 8'hF0;
   localparam logic [7:0] FourEnd  = 8'hF5;

   // sequence size codes
   localparam logic [2:0] SizeInvalid = 3'd0;
   localparam logic [2:0] SizeOne     = 3'd1;
   localparam logic [2:0] SizeTwo     = 3'd2;
   localparam logic [2:0] SizeThree   = 3'd3;
   localparam logic [2:0] SizeFour    = 3'd4;

   // one classified byte: a run of replacement results, then an optional tail
   typedef struct packed {
      logic [ErrWidth-1:0] err_count;
      logic                tail_vld;
      logic [CpWidth-1:0]  tail_cp;
      logic [LenWidth-1:0] tail_len;
   } cmd_type;

   function automatic logic [2:0] lead_size(input logic [7:0] b);
      logic [2:0] size;
      if (b < AsciiEnd) begin
         size = SizeOne;
      end else if (b < TwoBeg) begin
         size = SizeInvalid;
      end else if (b < ThreeBeg) begin
         size = SizeTwo;
      end else if (b < FourBeg) begin
         size = SizeThree;
      end else if (b < FourEnd) begin
         size = SizeFour;
      end else begin
         size = SizeInvalid;
      end
      return size;
   endfunction

endpackage

// ===== design/utf8_stream_decoder.sv =====
// A byte's command is registered in the command queue, and its first result is then
// registered in the output stage. The input takes one byte per cycle while the queue is
// not full. The result port moves one result per cycle while rsp_tready is high, so a
// byte with several results makes a burst, which the four-entry command queue between
// classifier and sequencer absorbs. Reset (synchronous, active high) drops any held
// sequence, empties the queue and clears the result valid.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Validating UTF-8 decoder: byte stream in, code points with lengths out.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = u8sd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [20:0] code_point, [23:21] byte_length
   output logic        rsp_tuser,    // is_invalid
   output logic        rsp_tlast     // last_of_run
);

   u8sd_pkg::cmd_type push_cmd;
   u8sd_pkg::cmd_type head_cmd;
   logic              cmd_push;
   logic              cmd_pop;
   logic              queue_empty;
   logic              queue_full;

   u8sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   u8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   u8sd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .queue_pop   (cmd_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== design/u8sd_front.sv =====
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts one byte per beat, tracks the pending sequence and turns each
// byte into a command: a count of replacement results and an optional tail.
// ----------------------------------------------------------------------------
module u8sd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] data_byte
   input  logic               req_tlast,   // end_of_stream
   input  logic               queue_full,
   output logic               cmd_push,
   output u8sd_pkg::cmd_type  cmd
);

   logic [7:0]  held_lead_ff,     held_lead_in;
   logic [1:0]  held_count_ff,    held_count_in;
   logic [20:0] partial_value_ff, partial_value_in;

   logic [2:0] held_size;
   logic [2:0] byte_size;
   logic [7:0] sec_lo;
   logic [7:0] sec_hi;
   logic [7:0] range_lo;
   logic [7:0] range_hi;
   logic       cont_ok;
   logic [2:0] count_up;
   logic       accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      held_size = u8sd_pkg::lead_size(held_lead_ff);
      byte_size = u8sd_pkg::lead_size(req_tdata);

      sec_lo = (held_lead_ff == u8sd_pkg::LeadE0) ? u8sd_pkg::E0SecLo :
               (held_lead_ff == u8sd_pkg::LeadF0) ? u8sd_pkg::F0SecLo : u8sd_pkg::ContLo;
      sec_hi = (held_lead_ff == u8sd_pkg::LeadEd) ? u8sd_pkg::EdSecHi :
               (held_lead_ff == u8sd_pkg::LeadF4) ? u8sd_pkg::F4SecHi : u8sd_pkg::ContHi;
      range_lo = (held_count_ff == 2'd1) ? sec_lo : u8sd_pkg::ContLo;
      range_hi = (held_count_ff == 2'd1) ? sec_hi : u8sd_pkg::ContHi;

      cont_ok  = (held_count_ff != 2'd0) && (held_size >= u8sd_pkg::SizeTwo) &&
                 (req_tdata >= range_lo) && (req_tdata <= range_hi);
      count_up = {1'b0, held_count_ff} + 3'd1;

      cmd              = '0;
      held_lead_in     = held_lead_ff;
      held_count_in    = held_count_ff;
      partial_value_in = partial_value_ff;

      if (cont_ok) begin
         partial_value_in = {partial_value_ff[14:0], req_tdata[5:0]};
         if (count_up == held_size) begin
            cmd.tail_vld     = 1'b1;
            cmd.tail_cp      = partial_value_in;
            cmd.tail_len     = held_size;
            held_lead_in     = '0;
            held_count_in    = '0;
            partial_value_in = '0;
         end else begin
            held_count_in = count_up[1:0];
            if (req_tlast) begin
               // flush the bytes still held as errors
               cmd.err_count    = count_up;
               held_lead_in     = '0;
               held_count_in    = '0;
               partial_value_in = '0;
            end
         end
      end else begin
         // drop any held sequence, then decode this byte as a lead
         cmd.err_count    = {1'b0, held_count_ff};
         held_lead_in     = '0;
         held_count_in    = '0;
         partial_value_in = '0;
         case (byte_size)
            u8sd_pkg::SizeOne: begin
               cmd.tail_vld = 1'b1;
               cmd.tail_cp  = {13'd0, req_tdata};
               cmd.tail_len = u8sd_pkg::SizeOne;
            end
            u8sd_pkg::SizeInvalid: begin
               cmd.err_count = cmd.err_count + 3'd1;
            end
            default: begin
               if (req_tlast) begin
                  cmd.err_count = cmd.err_count + 3'd1;
               end else begin
                  held_lead_in  = req_tdata;
                  held_count_in = 2'd1;
                  case (byte_size)
                     u8sd_pkg::SizeTwo:   partial_value_in = {13'd0, req_tdata & u8sd_pkg::Mask2};
                     u8sd_pkg::SizeThree: partial_value_in = {13'd0, req_tdata & u8sd_pkg::Mask3};
                     default:             partial_value_in = {13'd0, req_tdata & u8sd_pkg::Mask4};
                  endcase
               end
            end
         endcase
      end
   end

   assign cmd_push = accept && ((cmd.err_count != '0) || cmd.tail_vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff     <= '0;
         held_count_ff    <= '0;
         partial_value_ff <= '0;
      end else if (accept) begin
         held_lead_ff     <= held_lead_in;
         held_count_ff    <= held_count_in;
         partial_value_ff <= partial_value_in;
      end
   end

   // a held sequence always has a multi-byte lead and is not yet complete
   assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 2'd0) |->
         ((held_size >= u8sd_pkg::SizeTwo) && ({1'b0, held_count_ff} < held_size)))
      else $error("front: held sequence inconsistent with its lead");

   // end of stream leaves nothing held
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (held_count_ff == 2'd0))
      else $error("front: bytes still held after end of stream");

endmodule

// ===== design/u8sd_queue.sv =====
// ----------------------------------------------------------------------------
// u8sd_queue
// Short command queue in flip-flops between the classifier and the
// result sequencer.
// ----------------------------------------------------------------------------
module u8sd_queue #(
   parameter int unsigned DEPTH = u8sd_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8sd_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output u8sd_pkg::cmd_type  head_cmd,
   output logic               empty,
   output logic               full
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   u8sd_pkg::cmd_type entry_ff [DEPTH];

   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff,  count_in;
   logic                do_push;
   logic                do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FullCnt);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ((wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ((rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // the front never offers a command into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue: push while full");

endmodule

// ===== design/u8sd_back.sv =====
// ----------------------------------------------------------------------------
// u8sd_back
// Expands each queued command into its results, one per beat, into a
// registered output stage.
// ----------------------------------------------------------------------------
module u8sd_back (
   input  logic               clock,
   input  logic               reset,
   input  u8sd_pkg::cmd_type  head_cmd,
   input  logic               queue_empty,
   output logic               queue_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // [20:0] code_point, [23:21] byte_length
   output logic               rsp_tuser,   // is_invalid
   output logic               rsp_tlast    // last_of_run
);

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [20:0] code_point_ff;
   logic [2:0]  byte_length_ff;
   logic        is_invalid_ff;
   logic        last_ff;
   logic [2:0]  err_done_ff, err_done_in;

   logic        out_load;
   logic        step;
   logic        at_err;
   logic        is_last;

   always_comb begin
      out_load      = !rsp_tvalid_ff || rsp_tready;
      step          = out_load && !queue_empty;
      at_err        = (err_done_ff < head_cmd.err_count);
      is_last       = at_err ? (((err_done_ff + 3'd1) == head_cmd.err_count) &&
                                !head_cmd.tail_vld)
                             : 1'b1;
      queue_pop     = step && is_last;
      rsp_tvalid_in = out_load ? !queue_empty : rsp_tvalid_ff;
      err_done_in   = err_done_ff;
      if (step) begin
         err_done_in = is_last ? 3'd0 : err_done_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         err_done_ff   <= '0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         err_done_ff   <= err_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         code_point_ff  <= at_err ? u8sd_pkg::Replacement : head_cmd.tail_cp;
         byte_length_ff <= at_err ? u8sd_pkg::SizeOne     : head_cmd.tail_len;
         is_invalid_ff  <= at_err;
         last_ff        <= is_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {byte_length_ff, code_point_ff};
   assign rsp_tuser  = is_invalid_ff;
   assign rsp_tlast  = last_ff;

   // the error counter never runs past the head command's error run
   assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> (err_done_ff <= head_cmd.err_count))
      else $error("back: error counter past command");

   // a replacement result always carries 0xFFFD and length one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && is_invalid_ff) |->
         ((code_point_ff == u8sd_pkg::Replacement) && (byte_length_ff == u8sd_pkg::SizeOne)))
      else $error("back: malformed replacement result");

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the validating UTF-8 decoder. A directed byte list
// walks the lead classes, narrowed second-byte ranges, broken and truncated
// sequences, then a random stream of mostly well-formed encodings follows.
// Every accepted byte is decoded by a bench-side tracker and every result beat
// is checked in order against it, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

   localparam int unsigned RandomBytes = 400;
   localparam int unsigned IdleLimit   = 4000;
   localparam int unsigned HoldOffLen  = 200;
   localparam int unsigned DrainCycles = 20;

   typedef struct packed {
      logic [u8sd_pkg::CpWidth-1:0]  cp;
      logic [u8sd_pkg::LenWidth-1:0] len;
      logic                          invalid;
      logic                          last;
   } code_point_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } stream_byte_type;

   // Tracks the decoder state and holds the code points still to come out.
   class code_point_tracker;
      logic [7:0]                   held_lead;
      int unsigned                  held_count;
      logic [u8sd_pkg::CpWidth-1:0] partial;
      code_point_type               pending_cps[$];
      int unsigned                  bytes_noted;
      int unsigned                  mismatches;

      function new();
         held_lead   = '0;
         held_count  = 0;
         partial     = '0;
         bytes_noted = 0;
         mismatches  = 0;
      endfunction

      function logic [2:0] seq_len(input logic [7:0] b);
         if (b <= 8'h7F) return u8sd_pkg::SizeOne;
         if (b <= 8'hC1) return u8sd_pkg::SizeInvalid;
         if (b <= 8'hDF) return u8sd_pkg::SizeTwo;
         if (b <= 8'hEF) return u8sd_pkg::SizeThree;
         if (b <= 8'hF4) return u8sd_pkg::SizeFour;
         return u8sd_pkg::SizeInvalid;
      endfunction

      function void drop_held(ref code_point_type run[$]);
         code_point_type bad;
         bad = '{cp: u8sd_pkg::Replacement, len: 3'd1, invalid: 1'b1, last: 1'b0};
         repeat (held_count) run.push_back(bad);
         held_count = 0;
         held_lead  = '0;
         partial    = '0;
      endfunction

      function void note_byte(input logic [7:0] b, input logic eos);
         code_point_type run[$];
         logic [2:0]     size;
         logic [7:0]     lo;
         logic [7:0]     hi;
         bit             taken;
         taken = 0;
         bytes_noted++;
         if (held_count != 0) begin
            size = seq_len(held_lead);
            lo   = u8sd_pkg::ContLo;
            hi   = u8sd_pkg::ContHi;
            if (held_count == 1) begin
               if (held_lead == u8sd_pkg::LeadE0) lo = u8sd_pkg::E0SecLo;
               if (held_lead == u8sd_pkg::LeadF0) lo = u8sd_pkg::F0SecLo;
               if (held_lead == u8sd_pkg::LeadEd) hi = u8sd_pkg::EdSecHi;
               if (held_lead == u8sd_pkg::LeadF4) hi = u8sd_pkg::F4SecHi;
            end
            if (size >= u8sd_pkg::SizeTwo && b >= lo && b <= hi) begin
               partial = {partial[u8sd_pkg::CpWidth-7:0], b[5:0]};
               held_count++;
               taken = 1;
               if (held_count >= size) begin
                  run.push_back('{cp: partial, len: size, invalid: 1'b0, last: 1'b0});
                  held_count = 0;
                  held_lead  = '0;
                  partial    = '0;
               end
            end else begin
               drop_held(run);
            end
         end
         if (!taken) begin
            size = seq_len(b);
            if (size == u8sd_pkg::SizeOne) begin
               run.push_back('{cp: u8sd_pkg::CpWidth'(b), len: 3'd1, invalid: 1'b0,
                               last: 1'b0});
            end else if (size == u8sd_pkg::SizeInvalid) begin
               run.push_back('{cp: u8sd_pkg::Replacement, len: 3'd1, invalid: 1'b1,
                               last: 1'b0});
            end else begin
               held_lead  = b;
               held_count = 1;
               case (size)
                  u8sd_pkg::SizeTwo:   partial = u8sd_pkg::CpWidth'(b & u8sd_pkg::Mask2);
                  u8sd_pkg::SizeThree: partial = u8sd_pkg::CpWidth'(b & u8sd_pkg::Mask3);
                  default:             partial = u8sd_pkg::CpWidth'(b & u8sd_pkg::Mask4);
               endcase
            end
         end
         if (eos && held_count != 0) drop_held(run);
         if (run.size() > 0) run[run.size()-1].last = 1'b1;
         foreach (run[i]) pending_cps.push_back(run[i]);
      endfunction

      function void check_result(input code_point_type got);
         code_point_type want;
         if (pending_cps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result cp=%h len=%0d inv=%b last=%b",
                        got.cp, got.len, got.invalid, got.last);
            return;
         end
         want = pending_cps.pop_front();
         if (got.cp !== want.cp || got.len !== want.len ||
             got.invalid !== want.invalid || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result mismatch exp cp=%h len=%0d inv=%b last=%b, ",
                        "got cp=%h len=%0d inv=%b last=%b",
                        want.cp, want.len, want.invalid, want.last,
                        got.cp, got.len, got.invalid, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   code_point_tracker tracker = new();
   stream_byte_type   byte_list[$];
   int unsigned       burst_left = 0;
   int unsigned       idle_cycles = 0;

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor both channels; outputs change only after the edge, so sample here.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result('{cp: rsp_tdata[20:0], len: rsp_tdata[23:21],
                                   invalid: rsp_tuser, last: rsp_tlast});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 == IdleLimit) begin
            $display("utf8_stream_decoder_tb failed");
            $finish;
         end
      end
   end

   // Result side: runs of varying readiness, plus one long hold-off to back up the input.
   initial begin
      bit          held_off;
      int unsigned mode;
      int unsigned run_len;
      int unsigned phase;
      held_off = 0;
      phase    = 0;
      @(posedge clock iff !reset);
      forever begin
         if (!held_off && tracker.bytes_noted >= 120) begin
            held_off = 1;
            rsp_tready <= 1'b0;
            repeat (HoldOffLen) @(posedge clock);
         end else begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(8, 60);
            repeat (run_len) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= (phase % 4 != 3);
               endcase
               phase++;
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic add_encoding(input int unsigned len, input int unsigned keep);
      logic [20:0] cp;
      logic [7:0]  enc[4];
      case (len)
         1: cp = 21'($urandom_range(0, 16'h7F));
         2: cp = 21'($urandom_range(16'h80, 16'h7FF));
         3: begin
            do cp = 21'($urandom_range(16'h800, 16'hFFFF));
            while (cp >= 21'h00D800 && cp <= 21'h00DFFF);
         end
         default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
      endcase
      case (len)
         1: enc[0] = cp[7:0];
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++)
         byte_list.push_back('{data: enc[i], eos: ($urandom_range(0, 39) == 0)});
   endtask

   task automatic build_random_stream();
      int unsigned kind;
      int unsigned len;
      while (byte_list.size() < RandomBytes) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            len = $urandom_range(1, 4);
            add_encoding(len, len);
         end else if (kind < 85) begin
            // truncate a sequence, then follow it with any byte at all
            len = $urandom_range(2, 4);
            add_encoding(len, $urandom_range(1, len - 1));
            byte_list.push_back('{data: 8'($urandom_range(0, 255)),
                                  eos: ($urandom_range(0, 39) == 0)});
         end else begin
            byte_list.push_back('{data: 8'($urandom_range(0, 255)),
                                  eos: ($urandom_range(0, 39) == 0)});
         end
      end
   endtask

   initial begin
      stream_byte_type directed[$];
      directed = '{
         '{8'h00, 1'b0}, '{8'h7F, 1'b0},                  // ascii extremes
         '{8'hC2, 1'b0}, '{8'h80, 1'b0},                  // smallest two-byte
         '{8'hE0, 1'b0}, '{8'h9F, 1'b0},                  // overlong three-byte
         '{8'hED, 1'b0}, '{8'hA0, 1'b0},                  // surrogate
         '{8'hEF, 1'b0}, '{8'hBF, 1'b0}, '{8'hBD, 1'b0},  // real U+FFFD
         '{8'hF4, 1'b0}, '{8'h8F, 1'b0}, '{8'hBF, 1'b0}, '{8'hBF, 1'b0},
         '{8'hF0, 1'b0}, '{8'h8F, 1'b0},                  // overlong four-byte
         '{8'hF1, 1'b0}, '{8'h80, 1'b0}, '{8'h80, 1'b0}, '{8'hC1, 1'b0},
         '{8'hFF, 1'b0}, '{8'hF5, 1'b0},                  // invalid leads
         '{8'hE1, 1'b1},                                  // truncated at end of stream
         '{8'hDF, 1'b0}, '{8'hBF, 1'b1}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i].data, directed[i].eos);
      build_random_stream();
      foreach (byte_list[i]) send_byte(byte_list[i].data, byte_list[i].eos);
      req_tvalid <= 1'b0;

      // let the monitor note the last beat before checking what is pending
      @(posedge clock);
      while (tracker.pending_cps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending_cps.size() == 0) begin
         $display("utf8_stream_decoder_tb passed");
      end else begin
         $display("utf8_stream_decoder_tb failed");
      end
      $finish;
   end

endmodule
